@@ sv/ltlv_pkg.sv @@
// ----------------------------------------------------------------------------
// ltlv_pkg
// Shared types and constants of the length-prefixed tlv message parser.
// ----------------------------------------------------------------------------
package ltlv_pkg;

	localparam int FIFO_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_SIZE_HI = 3'd0,
		PH_SIZE_LO = 3'd1,
		PH_VERSION = 3'd2,
		PH_COMMAND = 3'd3,
		PH_HEADER  = 3'd4,
		PH_VALUE   = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_VALUE    = 3'd0,
		K_COMPLETE = 3'd1,
		K_DROPPED  = 3'd2,
		K_READY    = 3'd3,
		K_STOP     = 3'd4,
		K_ACK      = 3'd5,
		K_ERROR    = 3'd6
	} kind_t;

	localparam logic [7:0]  PORT_TYPE = 8'h02;
	localparam logic [7:0]  CMD_READY = 8'h01;
	localparam logic [7:0]  CMD_STOP  = 8'h02;
	localparam logic [7:0]  ASCII_0   = 8'h30;
	localparam logic [7:0]  ASCII_9   = 8'h39;
	localparam logic [16:0] ACC_SAT   = 17'd65536;

	// result steps of one item, in emission order
	localparam int ST_VALUE    = 0;
	localparam int ST_COMPLETE = 1;
	localparam int ST_DROPPED  = 2;
	localparam int ST_READY    = 3;
	localparam int ST_ACK0     = 4;
	localparam int ST_ACK1     = 5;
	localparam int ST_ACK2     = 6;
	localparam int ST_ACK3     = 7;
	localparam int ST_STOP     = 8;
	localparam int ST_ERROR    = 9;
	localparam int NSTEPS      = 10;
	localparam int STEP_W      = $clog2(NSTEPS);

	typedef logic [NSTEPS-1:0] steps_t;

	typedef struct packed {
		steps_t      steps;
		logic [7:0]  tlv_type;
		logic [7:0]  data;
		logic [15:0] port;
	} desc_t;

	function automatic logic [7:0] ack_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h00;
			2'd1: r = 8'h02;
			2'd2: r = 8'h01;
			2'd3: r = 8'h03;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

@@ sv/ltlv_fifo.sv @@
// ----------------------------------------------------------------------------
// ltlv_fifo
// Small register queue between the parser front end and the result back end.
// ----------------------------------------------------------------------------
module ltlv_fifo #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/ltlv_front.sv @@
// ----------------------------------------------------------------------------
// ltlv_front
// Frame and tlv parser: takes one item per cycle while accept is high and
// classifies it into a descriptor of the results it causes.
// ----------------------------------------------------------------------------
module ltlv_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 cmd,
	input  logic [7:0]           data_byte,
	output logic                 desc_push,
	output ltlv_pkg::desc_t      desc
);

	ltlv_pkg::phase_t phase_q, phase_n;
	logic [7:0]  size_hi_q, size_hi_n;
	logic [15:0] frame_left_q, frame_left_n;
	logic [7:0]  command_q, command_n;
	logic [1:0]  hdr_cnt_q, hdr_cnt_n;
	logic [7:0]  type_q, type_n;
	logic [15:0] value_left_q, value_left_n;
	logic [7:0]  len_hi_q, len_hi_n;
	logic        is_two_q, is_two_n;
	logic [7:0]  first_byte_q, first_byte_n;
	logic [16:0] acc_q, acc_n;
	logic        bad_q, bad_n;
	logic [15:0] port_q, port_n;
	logic        locked_q, locked_n;

	logic        counts;
	logic [15:0] len;
	logic [20:0] acc_calc;
	logic [7:0]  cmd_eff;
	ltlv_pkg::steps_t steps;

	always_comb begin
		phase_n      = phase_q;
		size_hi_n    = size_hi_q;
		frame_left_n = frame_left_q;
		command_n    = command_q;
		hdr_cnt_n    = hdr_cnt_q;
		type_n       = type_q;
		value_left_n = value_left_q;
		len_hi_n     = len_hi_q;
		is_two_n     = is_two_q;
		first_byte_n = first_byte_q;
		acc_n        = acc_q;
		bad_n        = bad_q;
		port_n       = port_q;
		locked_n     = locked_q;
		counts       = 1'b0;
		steps        = '0;
		len          = {len_hi_q, data_byte};
		acc_calc     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
			+ 21'(data_byte - ltlv_pkg::ASCII_0);
		cmd_eff      = (phase_q == ltlv_pkg::PH_COMMAND) ? data_byte : command_q;

		if (accept) begin
			if (cmd) begin
				phase_n      = ltlv_pkg::PH_SIZE_HI;
				size_hi_n    = '0;
				frame_left_n = '0;
				command_n    = '0;
				hdr_cnt_n    = '0;
				type_n       = '0;
				value_left_n = '0;
				len_hi_n     = '0;
				is_two_n     = 1'b0;
				first_byte_n = '0;
				acc_n        = '0;
				bad_n        = 1'b0;
				port_n       = '0;
				locked_n     = 1'b0;
			end else if (!locked_q) begin
				case (phase_q)
					ltlv_pkg::PH_SIZE_HI: begin
						size_hi_n = data_byte;
						phase_n   = ltlv_pkg::PH_SIZE_LO;
					end
					ltlv_pkg::PH_SIZE_LO: begin
						if ({size_hi_q, data_byte} < 16'd2) begin
							locked_n                  = 1'b1;
							steps[ltlv_pkg::ST_ERROR] = 1'b1;
						end else begin
							frame_left_n = {size_hi_q, data_byte};
							port_n       = '0;
							hdr_cnt_n    = '0;
							phase_n      = ltlv_pkg::PH_VERSION;
						end
					end
					ltlv_pkg::PH_VERSION: begin
						counts  = 1'b1;
						phase_n = ltlv_pkg::PH_COMMAND;
					end
					ltlv_pkg::PH_COMMAND: begin
						counts    = 1'b1;
						command_n = data_byte;
						hdr_cnt_n = '0;
						phase_n   = ltlv_pkg::PH_HEADER;
					end
					ltlv_pkg::PH_HEADER: begin
						counts = 1'b1;
						case (hdr_cnt_q)
							2'd0: begin
								type_n    = data_byte;
								hdr_cnt_n = 2'd1;
							end
							2'd1: begin
								len_hi_n  = data_byte;
								hdr_cnt_n = 2'd2;
							end
							default: begin
								hdr_cnt_n    = '0;
								len_hi_n     = '0;
								value_left_n = len;
								is_two_n     = (len == 16'd2);
								first_byte_n = '0;
								acc_n        = '0;
								bad_n        = (len == '0);
								// zero length completes at once and never moves the port
								if (len == '0) begin
									steps[ltlv_pkg::ST_COMPLETE] = 1'b1;
								end else begin
									phase_n = ltlv_pkg::PH_VALUE;
								end
							end
						endcase
					end
					ltlv_pkg::PH_VALUE: begin
						counts = 1'b1;
						if (is_two_q && value_left_q == 16'd2) begin
							first_byte_n = data_byte;
						end
						if (data_byte < ltlv_pkg::ASCII_0 || data_byte > ltlv_pkg::ASCII_9) begin
							bad_n = 1'b1;
						end else begin
							acc_n = (acc_calc > 21'(ltlv_pkg::ACC_SAT))
								? ltlv_pkg::ACC_SAT : acc_calc[16:0];
						end
						steps[ltlv_pkg::ST_VALUE] = 1'b1;
						value_left_n = value_left_q - 1'b1;
						if (value_left_q == 16'd1) begin
							if (type_q == ltlv_pkg::PORT_TYPE) begin
								if (is_two_q) begin
									port_n = {first_byte_q, data_byte};
								end else if (!bad_n && acc_n != '0 && !acc_n[16]) begin
									port_n = acc_n[15:0];
								end
							end
							steps[ltlv_pkg::ST_COMPLETE] = 1'b1;
							phase_n   = ltlv_pkg::PH_HEADER;
							hdr_cnt_n = '0;
						end
					end
					default: begin
						phase_n = ltlv_pkg::PH_SIZE_HI;
					end
				endcase

				if (counts) begin
					frame_left_n = frame_left_q - 1'b1;
					if (frame_left_q == 16'd1) begin
						// value still owed at frame end
						if (phase_n == ltlv_pkg::PH_VALUE && value_left_n != '0) begin
							steps[ltlv_pkg::ST_DROPPED] = 1'b1;
						end
						if (cmd_eff == ltlv_pkg::CMD_READY) begin
							steps[ltlv_pkg::ST_READY] = 1'b1;
							steps[ltlv_pkg::ST_ACK0]  = 1'b1;
							steps[ltlv_pkg::ST_ACK1]  = 1'b1;
							steps[ltlv_pkg::ST_ACK2]  = 1'b1;
							steps[ltlv_pkg::ST_ACK3]  = 1'b1;
						end else if (cmd_eff == ltlv_pkg::CMD_STOP) begin
							steps[ltlv_pkg::ST_STOP] = 1'b1;
						end
						phase_n      = ltlv_pkg::PH_SIZE_HI;
						hdr_cnt_n    = '0;
						value_left_n = '0;
						command_n    = '0;
					end
				end
			end
		end
	end

	assign desc_push     = accept && (steps != '0);
	assign desc.steps    = steps;
	assign desc.tlv_type = type_q;
	assign desc.data     = data_byte;
	assign desc.port     = port_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ltlv_pkg::PH_SIZE_HI;
			size_hi_q    <= '0;
			frame_left_q <= '0;
			command_q    <= '0;
			hdr_cnt_q    <= '0;
			type_q       <= '0;
			value_left_q <= '0;
			len_hi_q     <= '0;
			is_two_q     <= 1'b0;
			first_byte_q <= '0;
			acc_q        <= '0;
			bad_q        <= 1'b0;
			port_q       <= '0;
			locked_q     <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			size_hi_q    <= size_hi_n;
			frame_left_q <= frame_left_n;
			command_q    <= command_n;
			hdr_cnt_q    <= hdr_cnt_n;
			type_q       <= type_n;
			value_left_q <= value_left_n;
			len_hi_q     <= len_hi_n;
			is_two_q     <= is_two_n;
			first_byte_q <= first_byte_n;
			acc_q        <= acc_n;
			bad_q        <= bad_n;
			port_q       <= port_n;
			locked_q     <= locked_n;
		end
	end

endmodule

@@ sv/ltlv_back.sv @@
// ----------------------------------------------------------------------------
// ltlv_back
// Result expander: turns each queued descriptor into its results, one per
// cycle while the output register is free or popped, into that register.
// ----------------------------------------------------------------------------
module ltlv_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fifo_empty,
	input  ltlv_pkg::desc_t      head,
	output logic                 fifo_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [2:0]           kind,
	output logic [7:0]           tlv_type,
	output logic [7:0]           out_byte,
	output logic [15:0]          port_num,
	output logic                 last
);

	ltlv_pkg::desc_t  work_q;
	logic             busy_q;
	logic             out_valid_q;
	ltlv_pkg::kind_t  kind_q;
	logic [7:0]       type_q;
	logic [7:0]       byte_q;
	logic [15:0]      port_q;
	logic             last_q;

	ltlv_pkg::desc_t            src;
	logic                       take;
	ltlv_pkg::steps_t           lowest;
	ltlv_pkg::steps_t           rest;
	logic [ltlv_pkg::STEP_W-1:0] idx;
	ltlv_pkg::kind_t            n_kind;
	logic [7:0]                 n_type;
	logic [7:0]                 n_byte;
	logic [15:0]                n_port;

	always_comb begin
		src    = busy_q ? work_q : head;
		take   = (busy_q || !fifo_empty) && (!out_valid_q || pop);
		lowest = src.steps & (~src.steps + 1'b1);
		rest   = src.steps & ~lowest;
		fifo_pop = take && !busy_q;
		idx = '0;
		for (int i = 0; i < ltlv_pkg::NSTEPS; i++) begin
			if (lowest[i]) begin
				idx = ltlv_pkg::STEP_W'(i);
			end
		end
		n_kind = ltlv_pkg::K_VALUE;
		n_type = '0;
		n_byte = '0;
		n_port = '0;
		case (idx)
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_VALUE): begin
				n_kind = ltlv_pkg::K_VALUE;
				n_type = src.tlv_type;
				n_byte = src.data;
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_COMPLETE): begin
				n_kind = ltlv_pkg::K_COMPLETE;
				n_type = src.tlv_type;
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_DROPPED): begin
				n_kind = ltlv_pkg::K_DROPPED;
				n_type = src.tlv_type;
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_READY): begin
				n_kind = ltlv_pkg::K_READY;
				n_port = src.port;
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_ACK0): begin
				n_kind = ltlv_pkg::K_ACK;
				n_byte = ltlv_pkg::ack_byte(2'd0);
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_ACK1): begin
				n_kind = ltlv_pkg::K_ACK;
				n_byte = ltlv_pkg::ack_byte(2'd1);
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_ACK2): begin
				n_kind = ltlv_pkg::K_ACK;
				n_byte = ltlv_pkg::ack_byte(2'd2);
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_ACK3): begin
				n_kind = ltlv_pkg::K_ACK;
				n_byte = ltlv_pkg::ack_byte(2'd3);
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_STOP): begin
				n_kind = ltlv_pkg::K_STOP;
			end
			ltlv_pkg::STEP_W'(ltlv_pkg::ST_ERROR): begin
				n_kind = ltlv_pkg::K_ERROR;
			end
			default: begin
				n_kind = ltlv_pkg::K_VALUE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_q.steps    <= rest;
			work_q.tlv_type <= src.tlv_type;
			work_q.data     <= src.data;
			work_q.port     <= src.port;
			kind_q          <= n_kind;
			type_q          <= n_type;
			byte_q          <= n_byte;
			port_q          <= n_port;
			last_q          <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q      <= (rest != '0);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty     = !out_valid_q;
	assign kind      = kind_q;
	assign tlv_type  = type_q;
	assign out_byte  = byte_q;
	assign port_num  = port_q;
	assign last      = last_q;

endmodule

@@ sv/length_prefixed_tlv_message_parser.sv @@
// Path: descriptor queue, then output register, which takes a result only while free or popped.
// Throughput: one item per cycle while full is low; the back end emits one result per cycle
// while the output register is free or popped; it stays on an item until all its results
// are out, and the descriptor queue (FIFO_DEPTH entries) absorbs the burst before full rises.
// Reset: arst_n clears parser state, queue and output register; a connection reset item
// clears parser state only, and results already queued still come out.
// ----------------------------------------------------------------------------
// length_prefixed_tlv_message_parser
// Deframes length-prefixed messages, forwards tlv values and reports frame events.
// ----------------------------------------------------------------------------
module length_prefixed_tlv_message_parser #(
	parameter int FIFO_DEPTH = ltlv_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [7:0]  tlv_type,
	output logic [7:0]  out_byte,
	output logic [15:0] port_num,
	output logic        last
);

	logic             accept;
	logic             desc_push;
	ltlv_pkg::desc_t  desc;
	ltlv_pkg::desc_t  head;
	logic             fifo_pop;
	logic             fifo_full;
	logic             fifo_empty;

	assign full   = fifo_full;
	assign accept = push && !fifo_full;

	ltlv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.data_byte (data_byte),
		.desc_push (desc_push),
		.desc      (desc)
	);

	ltlv_fifo #(
		.WIDTH ($bits(ltlv_pkg::desc_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (desc_push),
		.wr_data (desc),
		.rd_en   (fifo_pop),
		.rd_data (head),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	ltlv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.head       (head),
		.fifo_pop   (fifo_pop),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.tlv_type   (tlv_type),
		.out_byte   (out_byte),
		.port_num   (port_num),
		.last       (last)
	);

`ifndef SYNTHESIS
	// a framing error is always the only result of its item
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == ltlv_pkg::K_ERROR) |-> last)
		else $error("framing error result not marked last");

	// the ack message follows source ready with no gap
	a_ack_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && kind == ltlv_pkg::K_READY) |=>
		(!empty && kind == ltlv_pkg::K_ACK && out_byte == ltlv_pkg::ack_byte(2'd0)))
		else $error("ack item missing after source ready");

	// a descriptor written and not drained leaves the queue occupied
	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(desc_push && !fifo_pop) |=> !fifo_empty)
		else $error("descriptor lost in queue");
`endif

endmodule

@@ dv/length_prefixed_tlv_message_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_tlv_message_parser_tb
// Streams framed tlv messages, broken frames and noise through the parser with
// random idling on both sides and checks every result item against a
// byte-level model of the framing, tlv and port decoding rules.
// ----------------------------------------------------------------------------
module length_prefixed_tlv_message_parser_tb;

	localparam bit CMD_STREAM     = 1'b0;
	localparam bit CMD_CONN_RESET = 1'b1;
	localparam logic [7:0] ACK_SEQ [4] = '{8'h00, 8'h02, 8'h01, 8'h03};
	localparam int unsigned RANDOM_ITEMS = 330;
	localparam int unsigned HOLD_CYCLES  = 300;

	typedef struct {
		ltlv_pkg::kind_t kind;
		logic [7:0]      tlv_type;
		logic [7:0]      out_byte;
		logic [15:0]     port;
		logic            last;
	} tlv_event_t;

	class tlv_scoreboard;
		tlv_event_t  events[$];
		int unsigned mismatches;
		int unsigned step_count;

		ltlv_pkg::phase_t ph;
		logic [15:0] frame_size;
		logic [15:0] frame_left;
		logic [7:0]  command_code;
		logic [1:0]  header_count;
		logic [7:0]  current_type;
		logic [15:0] value_left;
		logic [15:0] value_length;
		logic [7:0]  value_first;
		logic [16:0] dec_acc;
		logic        dec_bad;
		logic [15:0] port_val;
		logic        locked;

		function new();
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			ph = ltlv_pkg::PH_SIZE_HI;
			frame_size = '0;
			frame_left = '0;
			command_code = '0;
			header_count = '0;
			current_type = '0;
			value_left = '0;
			value_length = '0;
			value_first = '0;
			dec_acc = '0;
			dec_bad = 1'b0;
			port_val = '0;
			locked = 1'b0;
		endfunction

		function int unsigned pending();
			return events.size();
		endfunction

		function void add(ltlv_pkg::kind_t k, logic [7:0] t, logic [7:0] ob,
				logic [15:0] p);
			tlv_event_t e;
			e.kind = k;
			e.tlv_type = t;
			e.out_byte = ob;
			e.port = p;
			e.last = 1'b0;
			events.push_back(e);
			step_count++;
		endfunction

		// two-byte port values are big-endian, anything else is ascii decimal
		function void commit_port(logic [7:0] lastb);
			if (current_type != ltlv_pkg::PORT_TYPE)
				return;
			if (value_length == 16'd2)
				port_val = {value_first, lastb};
			else if (!dec_bad && dec_acc >= 17'd1 && dec_acc < ltlv_pkg::ACC_SAT)
				port_val = dec_acc[15:0];
		endfunction

		// advance the parse by one accepted item and queue the results it causes
		function void parse_byte(bit c, logic [7:0] b);
			int unsigned acc;
			step_count = 0;
			if (c == CMD_CONN_RESET) begin
				clear_state();
				return;
			end
			if (locked)
				return;
			case (ph)
				ltlv_pkg::PH_SIZE_HI: begin
					frame_size = {b, 8'h00};
					ph = ltlv_pkg::PH_SIZE_LO;
					return;
				end
				ltlv_pkg::PH_SIZE_LO: begin
					frame_size[7:0] = b;
					if (frame_size < 16'd2) begin
						locked = 1'b1;
						add(ltlv_pkg::K_ERROR, 8'h00, 8'h00, 16'h0000);
						events[events.size()-1].last = 1'b1;
						return;
					end
					frame_left = frame_size;
					port_val = '0;
					header_count = '0;
					ph = ltlv_pkg::PH_VERSION;
					return;
				end
				ltlv_pkg::PH_VERSION: ph = ltlv_pkg::PH_COMMAND;
				ltlv_pkg::PH_COMMAND: begin
					command_code = b;
					header_count = '0;
					ph = ltlv_pkg::PH_HEADER;
				end
				ltlv_pkg::PH_HEADER: begin
					if (header_count == 2'd0) begin
						current_type = b;
						header_count = 2'd1;
					end else if (header_count == 2'd1) begin
						value_length = {b, 8'h00};
						header_count = 2'd2;
					end else begin
						value_length[7:0] = b;
						header_count = '0;
						value_left = value_length;
						value_first = '0;
						dec_acc = '0;
						dec_bad = (value_length == 16'd0);
						if (value_length == 16'd0) begin
							commit_port(8'h00);
							add(ltlv_pkg::K_COMPLETE, current_type, 8'h00, 16'h0000);
						end else begin
							ph = ltlv_pkg::PH_VALUE;
						end
					end
				end
				default: begin
					if (value_left == value_length)
						value_first = b;
					if (b < ltlv_pkg::ASCII_0 || b > ltlv_pkg::ASCII_9) begin
						dec_bad = 1'b1;
					end else begin
						acc = dec_acc * 10 + (b - ltlv_pkg::ASCII_0);
						dec_acc = (acc > ltlv_pkg::ACC_SAT) ? ltlv_pkg::ACC_SAT : acc[16:0];
					end
					add(ltlv_pkg::K_VALUE, current_type, b, 16'h0000);
					value_left = value_left - 16'd1;
					if (value_left == 16'd0) begin
						commit_port(b);
						add(ltlv_pkg::K_COMPLETE, current_type, 8'h00, 16'h0000);
						ph = ltlv_pkg::PH_HEADER;
						header_count = '0;
					end
				end
			endcase

			frame_left = frame_left - 16'd1;
			if (frame_left == 16'd0) begin
				if (ph == ltlv_pkg::PH_VALUE && value_left != 16'd0)
					add(ltlv_pkg::K_DROPPED, current_type, 8'h00, 16'h0000);
				if (command_code == ltlv_pkg::CMD_READY) begin
					add(ltlv_pkg::K_READY, 8'h00, 8'h00, port_val);
					for (int i = 0; i < 4; i++)
						add(ltlv_pkg::K_ACK, 8'h00, ACK_SEQ[i], 16'h0000);
				end else if (command_code == ltlv_pkg::CMD_STOP) begin
					add(ltlv_pkg::K_STOP, 8'h00, 8'h00, 16'h0000);
				end
				ph = ltlv_pkg::PH_SIZE_HI;
				header_count = '0;
				value_left = '0;
				command_code = '0;
			end
			if (step_count > 0)
				events[events.size()-1].last = 1'b1;
		endfunction

		function void check_result(logic [2:0] k, logic [7:0] t, logic [7:0] ob,
				logic [15:0] p, logic l);
			tlv_event_t e;
			if (events.size() == 0) begin
				$error("unexpected result: kind %0d type %0h byte %0h port %0d last %0b",
					k, t, ob, p, l);
				mismatches++;
				return;
			end
			e = events.pop_front();
			if (k !== e.kind) begin
				$error("kind: expected %0d, actual %0d", e.kind, k);
				mismatches++;
			end
			if (t !== e.tlv_type) begin
				$error("tlv_type: expected %0h, actual %0h", e.tlv_type, t);
				mismatches++;
			end
			if (ob !== e.out_byte) begin
				$error("out_byte: expected %0h, actual %0h", e.out_byte, ob);
				mismatches++;
			end
			if (p !== e.port) begin
				$error("port_num: expected %0d, actual %0d", e.port, p);
				mismatches++;
			end
			if (l !== e.last) begin
				$error("last: expected %0b, actual %0b", e.last, l);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        cmd = CMD_STREAM;
	logic [7:0]  data_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  tlv_type;
	logic [7:0]  out_byte;
	logic [15:0] port_num;
	logic        last;

	tlv_scoreboard sb = new();
	logic [7:0]    frame_q[$];
	int unsigned   items_sent = 0;
	bit            no_idle = 1'b0;
	bit            hold_req = 1'b0;

	length_prefixed_tlv_message_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.data_byte (data_byte),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.tlv_type  (tlv_type),
		.out_byte  (out_byte),
		.port_num  (port_num),
		.last      (last)
	);

	always #6 clk = ~clk;

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned gap_len();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(input bit c, input logic [7:0] d);
		int unsigned g;
		g = gap_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		data_byte <= d;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.parse_byte(c, d);
		items_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_item(CMD_STREAM, frame_q[i]);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// one frame with size prefix: mostly well formed, sometimes cut short or padded
	task automatic gen_random_frame();
		logic [7:0]  body[$];
		logic [7:0]  vals[$];
		logic [7:0]  ttype;
		logic [15:0] len;
		logic [15:0] fsize;
		int unsigned ntlv, r, v, nz, cut;
		bit          oversized;
		body = {};
		body.push_back(8'($urandom_range(0, 255)));
		r = $urandom_range(0, 9);
		body.push_back(r < 4 ? ltlv_pkg::CMD_READY
			: (r < 7 ? ltlv_pkg::CMD_STOP : 8'($urandom_range(0, 255))));
		ntlv = $urandom_range(0, 3);
		for (int t = 0; t < ntlv; t++) begin
			vals = {};
			oversized = 1'b0;
			ttype = ($urandom_range(0, 1) == 0) ? ltlv_pkg::PORT_TYPE
				: 8'($urandom_range(0, 255));
			if (ttype == ltlv_pkg::PORT_TYPE) begin
				r = $urandom_range(0, 9);
				if (r < 3) begin
					v = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 65535 : 0)
						: $urandom_range(0, 65535);
					vals.push_back(8'(v >> 8));
					vals.push_back(8'(v));
				end else if (r < 9) begin
					case ($urandom_range(0, 9))
						0: v = 0;
						1: v = 65535;
						2: v = 65536;
						3: v = 1;
						4: v = $urandom_range(65536, 999999);
						default: v = $urandom_range(1, 65535);
					endcase
					do begin
						vals.push_front(8'(ltlv_pkg::ASCII_0 + v % 10));
						v = v / 10;
					end while (v != 0);
					nz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
					repeat (nz) vals.push_front(ltlv_pkg::ASCII_0);
					// non-digit somewhere in the string
					if ($urandom_range(0, 3) == 0)
						vals[$urandom_range(0, vals.size() - 1)] = $urandom_range(0, 1)
							? 8'($urandom_range(0, 47)) : 8'($urandom_range(58, 255));
				end else begin
					repeat ($urandom_range(0, 5)) vals.push_back(8'($urandom_range(0, 255)));
				end
				len = 16'(vals.size());
			end else begin
				repeat ($urandom_range(0, 5)) vals.push_back(8'($urandom_range(0, 255)));
				len = 16'(vals.size());
				// declared length far beyond what the frame holds
				if ($urandom_range(0, 9) == 0) begin
					len = 16'($urandom_range(0, 65535)) | 16'h0100;
					oversized = 1'b1;
				end
			end
			body.push_back(ttype);
			body.push_back(len[15:8]);
			body.push_back(len[7:0]);
			body = {body, vals};
			if (oversized)
				break;
		end
		r = $urandom_range(0, 19);
		if (r < 2 && body.size() > 2) begin
			cut = $urandom_range(2, body.size() - 1);
			body = body[0:cut-1];
		end else if (r == 2) begin
			repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
		end
		fsize = 16'(body.size());
		frame_q = {fsize[15:8], fsize[7:0], body};
	endtask

	// result side: random pop gaps plus one long hold-off on request
	initial begin
		int unsigned stall_cnt;
		int unsigned g;
		stall_cnt = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(kind, tlv_type, out_byte, port_num, last);
			if (stall_cnt > 0) begin
				stall_cnt--;
				pop <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				stall_cnt = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else begin
				g = gap_len();
				if (g > 0) begin
					stall_cnt = g - 1;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	initial begin
		int unsigned rand_start, r, k;
		bit          held, paused;
		held = 1'b0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// port as big-endian ffff, zero-length port kept, partial header at frame end
		frame_q = '{8'h00, 8'h0B, 8'h00, ltlv_pkg::CMD_READY,
			ltlv_pkg::PORT_TYPE, 8'h00, 8'h02, 8'hFF, 8'hFF,
			ltlv_pkg::PORT_TYPE, 8'h00, 8'h00,
			8'h07};
		send_frame();
		// port tlv cut off by the frame end, then stop
		frame_q = '{8'h00, 8'h0A, 8'hFF, ltlv_pkg::CMD_STOP,
			ltlv_pkg::PORT_TYPE, 8'h00, 8'h09, 8'h31, 8'h32, 8'h30, 8'h39, 8'hFF};
		send_frame();
		// undersized frame locks up until a connection reset
		send_item(CMD_STREAM, 8'h00);
		send_item(CMD_STREAM, 8'h01);
		send_item(CMD_STREAM, 8'h5A);
		send_item(CMD_CONN_RESET, 8'hFF);
		send_item(CMD_CONN_RESET, 8'h00);

		rand_start = items_sent;
		while (items_sent - rand_start < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if (!held && items_sent - rand_start > 120) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && items_sent - rand_start > 240) begin
				wait_drained();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 84) begin
				gen_random_frame();
				send_frame();
			end else if (r < 90) begin
				// connection reset in the middle of a frame
				gen_random_frame();
				k = $urandom_range(1, frame_q.size() - 1);
				frame_q = frame_q[0:k-1];
				send_frame();
				send_item(CMD_CONN_RESET, 8'($urandom_range(0, 255)));
			end else if (r < 95) begin
				repeat ($urandom_range(1, 6)) send_item(CMD_STREAM, 8'($urandom_range(0, 255)));
				send_item(CMD_CONN_RESET, 8'($urandom_range(0, 255)));
			end else begin
				send_item(CMD_STREAM, 8'h00);
				send_item(CMD_STREAM, 8'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 3)) send_item(CMD_STREAM, 8'($urandom_range(0, 255)));
				send_item(CMD_CONN_RESET, 8'($urandom_range(0, 255)));
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

@@ files.f @@
sv/ltlv_pkg.sv
sv/ltlv_fifo.sv
sv/ltlv_front.sv
sv/ltlv_back.sv
sv/length_prefixed_tlv_message_parser.sv
dv/length_prefixed_tlv_message_parser_tb.sv
